/* hw/rtl/scsg_pkg.sv */
package scsg_pkg;

  localparam int STEP_COUNT_BITS = 24;
  localparam int FRACTION_BITS   = 16;

  localparam int PERIOD_W       = 16;
  localparam int DIST_W         = 24;
  localparam int DIST_FRAC_BITS = 8;
  localparam int SPM_W          = 8;
  localparam int PCT_W          = 6;
  localparam int CFG_DATA_W     = 16;
  localparam int CFG_INDEX_W    = 2;

  localparam int RAW_W  = DIST_W + SPM_W - DIST_FRAC_BITS;
  localparam int SAT_W  = (RAW_W > STEP_COUNT_BITS) ? RAW_W : STEP_COUNT_BITS;
  localparam int NUM_W  = STEP_COUNT_BITS + FRACTION_BITS;
  localparam int X_W    = FRACTION_BITS + 1;
  localparam int SQ_W   = 2 * X_W;
  localparam int S_W    = FRACTION_BITS + 3;
  localparam int BL_W   = S_W + PERIOD_W;

  // floor(n / 100) as floor((n >> 2) * ceil(2^k / 25) >> k)
  localparam int RAMP_PROD_W  = STEP_COUNT_BITS + PCT_W;
  localparam int QUARTER_W    = RAMP_PROD_W - 2;
  localparam int RECIP_SHIFT  = QUARTER_W + 5;
  localparam int RECIP_W      = RECIP_SHIFT - 4;
  localparam int RECIP_PROD_W = QUARTER_W + RECIP_W;
  localparam longint unsigned RECIP_25_FULL = ((64'd1 << RECIP_SHIFT) + 64'd24) / 64'd25;

  localparam int QUEUE_DEPTH = 2;

  localparam logic [PERIOD_W-1:0]        SLOW_RESET = PERIOD_W'(3000);
  localparam logic [PERIOD_W-1:0]        FAST_RESET = PERIOD_W'(300);
  localparam logic [SPM_W-1:0]           SPM_RESET  = SPM_W'(25);
  localparam logic [PCT_W-1:0]           PCT_RESET  = PCT_W'(20);
  localparam logic [PCT_W-1:0]           PCT_MAX    = PCT_W'(50);
  localparam logic [RECIP_W-1:0]         RECIP_25   = RECIP_W'(RECIP_25_FULL);
  localparam logic [STEP_COUNT_BITS-1:0] STEP_MAX   = '1;
  localparam logic [X_W-1:0]             ONE_Q      = X_W'(1) << FRACTION_BITS;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_SLOW = 2'd0,
    REG_FAST = 2'd1,
    REG_SPM  = 2'd2,
    REG_RAMP = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [PERIOD_W-1:0] slow_period;
    logic [PERIOD_W-1:0] fast_period;
    logic [SPM_W-1:0]    step_scale;
    logic [PCT_W-1:0]    ramp_percent;
  } cfg_t;

  typedef struct packed {
    logic                       start;
    logic [STEP_COUNT_BITS-1:0] total;
  } entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

/* hw/rtl/scsg_if.sv */
interface scsg_req_if;
  import scsg_pkg::*;
  logic              valid;
  logic              ready;
  logic              kind;
  logic [DIST_W-1:0] distance_q8;

  modport source (output valid, kind, distance_q8, input ready);
  modport sink (input valid, kind, distance_q8, output ready);
endinterface

interface scsg_res_if;
  import scsg_pkg::*;
  logic                valid;
  logic                ready;
  logic                step_level;
  logic                driver_disable;
  logic                busy_res;
  logic [PERIOD_W-1:0] period_now;

  modport source (output valid, step_level, driver_disable, busy_res, period_now,
                  input ready);
  modport sink (input valid, step_level, driver_disable, busy_res, period_now,
                output ready);
endinterface

/* hw/rtl/scsg_fifo.sv */
module scsg_fifo
  import scsg_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  entry_t    push_data,
  input  logic      pop,
  output entry_t    pop_data,
  output q_status_t status
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  entry_t             slots [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;

  function automatic logic [PTR_W-1:0] advance(input logic [PTR_W-1:0] ptr);
    return (ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : ptr + PTR_W'(1);
  endfunction

  assign status.full  = (count == CNT_W'(QUEUE_DEPTH));
  assign status.empty = (count == '0);
  assign pop_data     = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= advance(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= advance(rd_ptr);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

/* hw/rtl/scsg_front.sv */
module scsg_front
  import scsg_pkg::*;
(
  scsg_req_if.sink         req,
  input  logic [SPM_W-1:0] step_scale,
  input  q_status_t        q_stat,
  output logic             push,
  output entry_t           push_data
);

  logic [DIST_W+SPM_W-1:0] product;
  logic [RAW_W-1:0]        raw;
  logic [SAT_W-1:0]        raw_ext;

  assign product = (DIST_W+SPM_W)'(req.distance_q8) * (DIST_W+SPM_W)'(step_scale);
  assign raw     = product[DIST_W+SPM_W-1:DIST_FRAC_BITS];
  assign raw_ext = SAT_W'(raw);

  assign req.ready       = !q_stat.full;
  assign push            = req.valid && !q_stat.full;
  assign push_data.start = req.kind;
  assign push_data.total = (raw_ext > SAT_W'(STEP_MAX)) ? STEP_MAX
                                                        : STEP_COUNT_BITS'(raw_ext);

endmodule

/* hw/rtl/scsg_div.sv */
module scsg_div
  import scsg_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [NUM_W-1:0]           num,
  input  logic [STEP_COUNT_BITS-1:0] den,
  output logic                       done,
  output logic [NUM_W-1:0]           quo
);

  localparam int CNT_W = $clog2(NUM_W);

  logic                       active;
  logic [CNT_W-1:0]           cnt;
  logic [STEP_COUNT_BITS-1:0] rem;
  logic [STEP_COUNT_BITS:0]   trial;
  logic                       fits;

  assign trial = {rem, quo[NUM_W-1]};
  assign fits  = (trial >= {1'b0, den});

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
      cnt    <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        active <= 1'b1;
        cnt    <= '0;
      end else if (active) begin
        cnt <= cnt + CNT_W'(1);
        if (cnt == CNT_W'(NUM_W - 1)) begin
          active <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= num;
    end else if (active) begin
      rem <= fits ? STEP_COUNT_BITS'(trial - {1'b0, den}) : trial[STEP_COUNT_BITS-1:0];
      quo <= {quo[NUM_W-2:0], fits};
    end
  end

endmodule

/* hw/rtl/scsg_back.sv */
module scsg_back
  import scsg_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst,
  input  cfg_t                       cfg,
  input  q_status_t                  q_stat,
  input  entry_t                     pop_data,
  output logic                       pop,
  output logic                       div_start,
  output logic [NUM_W-1:0]           div_num,
  output logic [STEP_COUNT_BITS-1:0] div_den,
  input  logic                       div_done,
  input  logic [NUM_W-1:0]           div_quo,
  scsg_res_if.source                 res
);

  typedef enum logic [3:0] {
    IDLE, RAMP_SCALE, COAST_SET, X_DIV, SQUARE, CUBE, SMOOTH, BLEND, SETTLE
  } state_t;

  state_t                     state;
  logic [STEP_COUNT_BITS-1:0] steps_done;
  logic [STEP_COUNT_BITS-1:0] steps_total;
  logic [STEP_COUNT_BITS-1:0] ramp_len;
  logic [STEP_COUNT_BITS-1:0] coast_stop;
  logic [PERIOD_W-1:0]        period_reg;
  logic [PERIOD_W-1:0]        tick_counter;
  logic                       pulse_high;
  logic                       finished;
  logic                       running;
  logic                       res_valid;
  logic                       decel;
  logic                       slow_ge;
  logic [RAMP_PROD_W-1:0]     ramp_prod_r;
  logic [X_W-1:0]             x_r;
  logic [X_W-1:0]             x2_r;
  logic [X_W-1:0]             x3_r;
  logic [S_W-1:0]             s_r;
  logic [BL_W-1:0]            bl_r;

  logic [PCT_W-1:0]           pct_eff;
  logic                       hit;
  logic [STEP_COUNT_BITS-1:0] st_inc;
  logic [STEP_COUNT_BITS-1:0] dec_off;
  logic [RAMP_PROD_W-1:0]     ramp_prod;
  logic [RECIP_PROD_W-1:0]    ramp_scaled;
  logic [X_W-1:0]             x_clamp;
  logic [SQ_W-1:0]            sq;
  logic [SQ_W-1:0]            cu;
  logic [S_W-1:0]             s_sum;
  logic [PERIOD_W-1:0]        diff;
  logic [BL_W-1:0]            bl_ceil;
  logic [BL_W-FRACTION_BITS-1:0] bl_up;
  logic [BL_W-FRACTION_BITS-1:0] bl_down;
  logic [PERIOD_W-1:0]        period_new;

  assign pct_eff   = (cfg.ramp_percent > PCT_MAX) ? PCT_MAX : cfg.ramp_percent;
  assign pop       = (state == IDLE) && !q_stat.empty && (!res_valid || res.ready);
  assign hit       = (tick_counter >= period_reg);
  assign st_inc    = steps_done + STEP_COUNT_BITS'(1);
  assign dec_off   = st_inc - coast_stop;
  assign ramp_prod = RAMP_PROD_W'(pop_data.total) * RAMP_PROD_W'(pct_eff);
  assign ramp_scaled = RECIP_PROD_W'(ramp_prod_r[RAMP_PROD_W-1:RAMP_PROD_W-QUARTER_W]) *
                       RECIP_PROD_W'(RECIP_25);
  assign x_clamp   = (div_quo > NUM_W'(ONE_Q)) ? ONE_Q : div_quo[X_W-1:0];
  assign sq        = SQ_W'(x_r) * SQ_W'(x_r);
  assign cu        = SQ_W'(x2_r) * SQ_W'(x_r);
  assign s_sum     = S_W'({x2_r, 1'b0}) + S_W'(x2_r) - S_W'({x3_r, 1'b0});
  assign diff      = (cfg.slow_period >= cfg.fast_period) ?
                     cfg.slow_period - cfg.fast_period : cfg.fast_period - cfg.slow_period;
  assign bl_ceil   = bl_r + BL_W'(ONE_Q - X_W'(1));
  assign bl_up     = bl_ceil[BL_W-1:FRACTION_BITS];
  assign bl_down   = bl_r[BL_W-1:FRACTION_BITS];
  assign period_new = slow_ge ? cfg.slow_period - bl_up[PERIOD_W-1:0]
                              : cfg.slow_period + bl_down[PERIOD_W-1:0];

  assign res.valid          = res_valid;
  assign res.step_level     = pulse_high;
  assign res.driver_disable = finished;
  assign res.busy_res       = running;
  assign res.period_now     = period_reg;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= IDLE;
      steps_done   <= '0;
      steps_total  <= '0;
      ramp_len     <= '0;
      coast_stop   <= '0;
      period_reg   <= SLOW_RESET;
      tick_counter <= '0;
      pulse_high   <= 1'b0;
      finished     <= 1'b0;
      running      <= 1'b0;
      res_valid    <= 1'b0;
      div_start    <= 1'b0;
      decel        <= 1'b0;
    end else begin
      div_start <= 1'b0;
      if (res.ready) begin
        res_valid <= 1'b0;
      end
      case (state)
        IDLE: begin
          if (pop) begin
            if (pop_data.start) begin
              steps_total  <= pop_data.total;
              steps_done   <= '0;
              finished     <= 1'b0;
              pulse_high   <= 1'b0;
              tick_counter <= '0;
              period_reg   <= cfg.slow_period;
              running      <= 1'b1;
              ramp_prod_r  <= ramp_prod;
              state        <= RAMP_SCALE;
            end else if (running && hit) begin
              tick_counter <= '0;
              if (finished) begin
                running   <= 1'b0;
                res_valid <= 1'b1;
              end else if (pulse_high) begin
                pulse_high <= 1'b0;
                res_valid  <= 1'b1;
              end else begin
                pulse_high <= 1'b1;
                steps_done <= st_inc;
                if (st_inc >= steps_total) begin
                  finished  <= 1'b1;
                  res_valid <= 1'b1;
                end else if (st_inc < ramp_len) begin
                  div_start <= 1'b1;
                  div_num   <= NUM_W'(st_inc) << FRACTION_BITS;
                  div_den   <= ramp_len;
                  decel     <= 1'b0;
                  state     <= X_DIV;
                end else if (st_inc < coast_stop || ramp_len == '0) begin
                  period_reg <= cfg.fast_period;
                  res_valid  <= 1'b1;
                end else begin
                  div_start <= 1'b1;
                  div_num   <= NUM_W'(dec_off) << FRACTION_BITS;
                  div_den   <= ramp_len;
                  decel     <= 1'b1;
                  state     <= X_DIV;
                end
              end
            end else begin
              if (running) begin
                tick_counter <= tick_counter + PERIOD_W'(1);
              end
              res_valid <= 1'b1;
            end
          end
        end
        RAMP_SCALE: begin
          ramp_len <= ramp_scaled[RECIP_SHIFT+STEP_COUNT_BITS-1:RECIP_SHIFT];
          state    <= COAST_SET;
        end
        COAST_SET: begin
          coast_stop <= steps_total - ramp_len;
          res_valid  <= 1'b1;
          state      <= IDLE;
        end
        X_DIV: begin
          if (div_done) begin
            x_r   <= decel ? ONE_Q - x_clamp : div_quo[X_W-1:0];
            state <= SQUARE;
          end
        end
        SQUARE: begin
          x2_r  <= sq[FRACTION_BITS+X_W-1:FRACTION_BITS];
          state <= CUBE;
        end
        CUBE: begin
          x3_r  <= cu[FRACTION_BITS+X_W-1:FRACTION_BITS];
          state <= SMOOTH;
        end
        SMOOTH: begin
          s_r   <= s_sum;
          state <= BLEND;
        end
        BLEND: begin
          bl_r    <= BL_W'(s_r) * BL_W'(diff);
          slow_ge <= (cfg.slow_period >= cfg.fast_period);
          state   <= SETTLE;
        end
        SETTLE: begin
          period_reg <= period_new;
          res_valid  <= 1'b1;
          state      <= IDLE;
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

endmodule

/* hw/rtl/s_curve_step_pulse_generator_unit.sv */
// Step pulse generator with an S-curve speed profile for a stepper driver.
// req carries one request per item: kind 1 starts a move of distance_q8
// (1/256 mm), kind 0 is one prescaled timer tick. res returns one result
// per request: step pin level, driver disable, busy and the half-cycle
// period in use. Registers are written through cfg_we/cfg_index/cfg_data,
// by the user only while no request is in flight; not enforced by the block.
// A plain tick, or a tick that causes no rising step edge, gives its result
// from a register once popped, one per cycle back to back while res.ready
// stays high. A start request first scales the ramp by a reciprocal
// multiply, then sets the coast point. A rising edge inside a ramp runs the
// bit-serial divider, then the square, cube, smoothstep and blend stages in
// turn. Coast edges, the last edge and falling edges take the plain path.
// Requests enter a two-entry queue, so two more are taken while the back
// end works or while a result waits on res.ready; a stalled receiver holds
// the result stable and eventually stalls req.
// Synchronous reset empties the queue, stops the timer and loads the
// default registers (slow 3000, fast 300, 25 steps/mm, 20 percent ramp).
module s_curve_step_pulse_generator_unit
  import scsg_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  scsg_req_if.sink               req,
  scsg_res_if.source             res,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  cfg_t                       cfg;
  q_status_t                  q_stat;
  logic                       push;
  entry_t                     push_data;
  logic                       pop;
  entry_t                     pop_data;
  logic                       div_start;
  logic [NUM_W-1:0]           div_num;
  logic [STEP_COUNT_BITS-1:0] div_den;
  logic                       div_done;
  logic [NUM_W-1:0]           div_quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.slow_period  <= SLOW_RESET;
      cfg.fast_period  <= FAST_RESET;
      cfg.step_scale   <= SPM_RESET;
      cfg.ramp_percent <= PCT_RESET;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_SLOW: cfg.slow_period  <= cfg_data[PERIOD_W-1:0];
        REG_FAST: cfg.fast_period  <= cfg_data[PERIOD_W-1:0];
        REG_SPM:  cfg.step_scale   <= cfg_data[SPM_W-1:0];
        REG_RAMP: cfg.ramp_percent <= cfg_data[PCT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  scsg_front u_front (
    .req        (req),
    .step_scale (cfg.step_scale),
    .q_stat     (q_stat),
    .push       (push),
    .push_data  (push_data)
  );

  scsg_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .status    (q_stat)
  );

  scsg_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  scsg_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_stat    (q_stat),
    .pop_data  (pop_data),
    .pop       (pop),
    .div_start (div_start),
    .div_num   (div_num),
    .div_den   (div_den),
    .div_done  (div_done),
    .div_quo   (div_quo),
    .res       (res)
  );

  a_done_pin_high: assert property (@(posedge clk) disable iff (rst)
    res.valid && res.driver_disable |-> res.step_level)
    else $error("finished move reported with step pin low");

  a_idle_pin_low: assert property (@(posedge clk) disable iff (rst)
    res.valid && !res.busy_res && !res.driver_disable |-> !res.step_level)
    else $error("idle block reported with step pin high");

  a_no_pop_when_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> !q_stat.empty)
    else $error("queue popped while empty");

  a_div_start_idle: assert property (@(posedge clk) disable iff (rst)
    div_start |=> !div_done)
    else $error("divider reported done right after start");

endmodule
